// ===== sv/evpa_pkg.sv =====
// Shared constants, types and helper functions of the ellipse parametric angle core.
`default_nettype none
package evpa_pkg;

	localparam int COORD_BITS = 32;
	localparam int ANGLE_BITS = 16;
	localparam int SC_W       = 24;
	localparam int CFG_W      = (COORD_BITS > SC_W) ? COORD_BITS : SC_W;
	localparam int IDX_W      = 3;

	localparam int STEPS  = 30;
	localparam int STEP_W = 5;
	localparam int TURN_W = 32;

	localparam int AX_W   = 34;
	localparam int NV_W   = 31;
	localparam int PR_W   = AX_W + NV_W;
	localparam int U_W    = PR_W + 2 - 30;
	localparam int P_W    = 63;
	localparam int MAGP_W = P_W;
	localparam int X_W    = 57;
	localparam int POS_W  = 6;

	localparam int NV_TOP = 29;
	localparam int P_TOP  = 52;
	localparam int Y_FRAC = 16;

	localparam logic signed [AX_W-1:0] GAIN_Q30 = AX_W'(652032874);

	localparam logic [TURN_W-1:0] TURN_QUARTER = 32'h4000_0000;
	localparam logic [TURN_W-1:0] TURN_HALF    = 32'h8000_0000;
	localparam logic [TURN_W-1:0] TURN_3QUART  = 32'hC000_0000;

	localparam logic [IDX_W-1:0] REG_MINOR   = 3'd0;
	localparam logic [IDX_W-1:0] REG_SCALE   = 3'd1;
	localparam logic [IDX_W-1:0] REG_SPIN    = 3'd2;
	localparam logic [IDX_W-1:0] REG_TILT    = 3'd3;
	localparam logic [IDX_W-1:0] REG_HEADING = 3'd4;

	typedef struct packed {
		logic                    vld;
		logic                    fix;
		logic                    degen;
		logic signed [X_W-1:0]   x;
		logic signed [X_W-1:0]   y;
		logic [TURN_W-1:0]       z;
	} cell_t;

	function automatic logic [TURN_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
		logic [TURN_W-1:0] r;
		case (i)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41721;
			5'd15: r = 32'd20860;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2607;
			5'd19: r = 32'd1303;
			5'd20: r = 32'd651;
			5'd21: r = 32'd325;
			5'd22: r = 32'd162;
			5'd23: r = 32'd81;
			5'd24: r = 32'd40;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd2;
			5'd29: r = 32'd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [POS_W-1:0] lead_pos(input logic [MAGP_W-1:0] m);
		logic [POS_W-1:0] p;
		p = '0;
		for (int i = 0; i < MAGP_W; i++) begin
			if (m[i]) p = POS_W'(i);
		end
		return p;
	endfunction

	function automatic logic signed [AX_W-1:0] mulq(input logic signed [AX_W-1:0] a,
			input logic signed [AX_W-1:0] b);
		logic signed [2*AX_W-1:0] pr;
		pr = (2*AX_W)'(a) * (2*AX_W)'(b);
		return AX_W'(pr >>> 30);
	endfunction

endpackage
`default_nettype wire

// ===== sv/ellipse_vector_param_angle_core.sv =====
// Top level: configuration registers, axis setup, front pipeline and vectoring cell chain.
// Stages from an accepted input word to its result word: 10 front stages, 30 vectoring cells,
//   1 output register; one word per cycle sustained while neither out_stall nor axis setup stalls input.
// The whole pipeline advances as one while the output register is free or being taken.
// After reset and after a write to an angle register, the axis sequencer runs its
//   three sine/cosine passes and three product steps; input is stalled meanwhile.
// Reset: registers return to axis_scale 65536, angles 0; pipeline empty.
`default_nettype none
module ellipse_vector_param_angle_core
	import evpa_pkg::*;
(
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [IDX_W-1:0]               cfg_index,
	input  wire logic [CFG_W-1:0]               cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [COORD_BITS-1:0]   vec_x,
	input  wire logic signed [COORD_BITS-1:0]   vec_y,
	input  wire logic signed [COORD_BITS-1:0]   vec_z,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [ANGLE_BITS-1:0]               param_angle,
	output logic                                degenerate
);

	logic [SC_W-1:0]       axis_scale_q;
	logic [ANGLE_BITS-1:0] spin_q, tilt_q, heading_q;

	logic                   busy, en, take, start;
	logic signed [AX_W-1:0] a1 [3];
	logic signed [AX_W-1:0] a2 [3];
	cell_t                  chain [STEPS+1];
	logic [TURN_W-1:0]      zr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_scale_q <= SC_W'(65536);
			spin_q       <= '0;
			tilt_q       <= '0;
			heading_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MINOR:   ;
				REG_SCALE:   axis_scale_q <= cfg_data[SC_W-1:0];
				REG_SPIN:    spin_q       <= cfg_data[ANGLE_BITS-1:0];
				REG_TILT:    tilt_q       <= cfg_data[ANGLE_BITS-1:0];
				REG_HEADING: heading_q    <= cfg_data[ANGLE_BITS-1:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		start    = cfg_we && (cfg_index inside {REG_SPIN, REG_TILT, REG_HEADING});
		en       = !out_valid || !out_stall;
		in_stall = !en || busy;
		take     = in_valid && !in_stall;
		zr       = chain[STEPS].z + (TURN_W'(1) << (TURN_W - 1 - ANGLE_BITS));
	end

	evpa_axis u_axis (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.spin    (spin_q),
		.tilt    (tilt_q),
		.heading (heading_q),
		.busy    (busy),
		.a1      (a1),
		.a2      (a2)
	);

	evpa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.take       (take),
		.vec_x      (vec_x),
		.vec_y      (vec_y),
		.vec_z      (vec_z),
		.axis_scale (axis_scale_q),
		.a1         (a1),
		.a2         (a2),
		.head       (chain[0])
	);

	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		evpa_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.step   (STEP_W'(i)),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= chain[STEPS].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			param_angle <= zr[TURN_W-1 -: ANGLE_BITS];
			degenerate  <= chain[STEPS].degen;
		end
	end

`ifndef SYNTH
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall) else $error("input word taken during axis setup");
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall) else $error("input word taken while frozen");
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |-> (param_angle == '0)) else $error("degenerate word not zero");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy) else $error("angle write did not restart axis setup");
`endif

endmodule
`default_nettype wire

// ===== sv/evpa_axis.sv =====
// Axis vector setup: sine and cosine of the three ellipse angles and the two axis vectors.
`default_nettype none
module evpa_axis
	import evpa_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [ANGLE_BITS-1:0]        spin,
	input  wire logic [ANGLE_BITS-1:0]        tilt,
	input  wire logic [ANGLE_BITS-1:0]        heading,
	output logic                              busy,
	output logic signed [AX_W-1:0]            a1 [3],
	output logic signed [AX_W-1:0]            a2 [3]
);

	typedef enum logic [2:0] {
		ST_LOAD, ST_ROT, ST_STORE, ST_MUL1, ST_MUL2, ST_SUM, ST_IDLE
	} state_t;

	state_t              state_q;
	logic [1:0]          ang_q;
	logic [STEP_W-1:0]   step_q;

	logic signed [AX_W-1:0] x_q, y_q, z_q;
	logic [1:0]             quad_q;
	logic signed [AX_W-1:0] cos_q [3];
	logic signed [AX_W-1:0] sin_q [3];
	logic signed [AX_W-1:0] cpca_q, cpsa_q, spca_q, spsa_q, stsa_q, stca_q, ctsp_q, ctcp_q;
	logic signed [AX_W-1:0] tspsa_q, tcpsa_q, tspca_q, tcpca_q;

	logic [ANGLE_BITS-1:0]  sel_ang;
	logic [TURN_W-1:0]      t, rem;
	logic [1:0]             quad;
	logic signed [AX_W-1:0] atn, nx, ny, nz, c_o, s_o;

	always_comb begin
		case (ang_q)
			2'd0:    sel_ang = spin;
			2'd1:    sel_ang = tilt;
			default: sel_ang = heading;
		endcase
		t    = TURN_W'(sel_ang) << (TURN_W - ANGLE_BITS);
		quad = 2'((t + TURN_QUARTER / 2) >> 30);
		rem  = t - (TURN_W'(quad) << 30);
		atn  = AX_W'(atan_turn(step_q));
		if (z_q >= 0) begin
			nx = x_q - (y_q >>> step_q);
			ny = y_q + (x_q >>> step_q);
			nz = z_q - atn;
		end else begin
			nx = x_q + (y_q >>> step_q);
			ny = y_q - (x_q >>> step_q);
			nz = z_q + atn;
		end
		case (quad_q)
			2'd0:    begin c_o = x_q;  s_o = y_q;  end
			2'd1:    begin c_o = -y_q; s_o = x_q;  end
			2'd2:    begin c_o = -x_q; s_o = -y_q; end
			default: begin c_o = y_q;  s_o = -x_q; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			ang_q   <= '0;
			step_q  <= '0;
		end else if (start) begin
			state_q <= ST_LOAD;
			ang_q   <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					state_q <= ST_ROT;
					step_q  <= '0;
				end
				ST_ROT: begin
					if (step_q == STEP_W'(STEPS - 1)) state_q <= ST_STORE;
					step_q <= step_q + 1'b1;
				end
				ST_STORE: begin
					if (ang_q == 2'd2) begin
						state_q <= ST_MUL1;
					end else begin
						ang_q   <= ang_q + 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				x_q    <= GAIN_Q30;
				y_q    <= '0;
				z_q    <= AX_W'($signed(rem));
				quad_q <= quad;
			end
			ST_ROT: begin
				x_q <= nx;
				y_q <= ny;
				z_q <= nz;
			end
			ST_STORE: begin
				cos_q[ang_q] <= c_o;
				sin_q[ang_q] <= s_o;
			end
			ST_MUL1: begin
				cpca_q <= mulq(cos_q[2], cos_q[0]);
				cpsa_q <= mulq(cos_q[2], sin_q[0]);
				spca_q <= mulq(sin_q[2], cos_q[0]);
				spsa_q <= mulq(sin_q[2], sin_q[0]);
				stsa_q <= mulq(sin_q[1], sin_q[0]);
				stca_q <= mulq(sin_q[1], cos_q[0]);
				ctsp_q <= mulq(cos_q[1], sin_q[2]);
				ctcp_q <= mulq(cos_q[1], cos_q[2]);
			end
			ST_MUL2: begin
				tspsa_q <= mulq(ctsp_q, sin_q[0]);
				tcpsa_q <= mulq(ctcp_q, sin_q[0]);
				tspca_q <= mulq(ctsp_q, cos_q[0]);
				tcpca_q <= mulq(ctcp_q, cos_q[0]);
			end
			ST_SUM: begin
				a1[0] <= cpca_q - tspsa_q;
				a1[1] <= spca_q + tcpsa_q;
				a1[2] <= stsa_q;
				a2[0] <= -cpsa_q - tspca_q;
				a2[1] <= -spsa_q + tcpca_q;
				a2[2] <= stca_q;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

// ===== sv/evpa_front.sv =====
// Front pipeline: vector normalize, projection onto the axes, scale and pair normalize.
`default_nettype none
module evpa_front
	import evpa_pkg::*;
(
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           take,
	input  wire logic signed [COORD_BITS-1:0]   vec_x,
	input  wire logic signed [COORD_BITS-1:0]   vec_y,
	input  wire logic signed [COORD_BITS-1:0]   vec_z,
	input  wire logic [SC_W-1:0]                axis_scale,
	input  wire logic signed [AX_W-1:0]         a1 [3],
	input  wire logic signed [AX_W-1:0]         a2 [3],
	output cell_t                               head
);

	logic [9:1] vld_q;

	logic signed [COORD_BITS-1:0] v_s1 [3];
	logic [COORD_BITS-1:0]        mag_s2 [3];
	logic [2:0]                   neg_s2;
	logic [COORD_BITS-1:0]        or_s2;
	logic [COORD_BITS-1:0]        mag_s3 [3];
	logic [2:0]                   neg_s3;
	logic [POS_W-1:0]             sh_s3;
	logic                         right_s3, zero_s3;
	logic signed [NV_W-1:0]       nv_s4 [3];
	logic                         zero_s4;
	logic signed [PR_W-1:0]       pu_s5 [3];
	logic signed [PR_W-1:0]       pw_s5 [3];
	logic                         zero_s5;
	logic signed [U_W-1:0]        u_s6, w_s6;
	logic                         zero_s6;
	logic signed [P_W-1:0]        px_s7, py_s7;
	logic                         zero_s7;
	logic [MAGP_W-1:0]            mx_s8, my_s8;
	logic                         nx_s8, ny_s8, zero_s8;
	logic [MAGP_W-1:0]            mx_s9, my_s9;
	logic                         nx_s9, ny_s9, zero_s9, right_s9, none_s9;
	logic [POS_W-1:0]             sh_s9;

	logic [POS_W-1:0]             pos1, pos2;
	logic [MAGP_W-1:0]            sm [3];
	logic signed [PR_W+1:0]       su, sw;
	logic signed [SC_W:0]         sc;
	logic [MAGP_W-1:0]            smx, smy;
	logic signed [X_W-1:0]        hx, hy;
	cell_t                        hd;

	always_comb begin
		pos1 = lead_pos(MAGP_W'(or_s2));
		for (int i = 0; i < 3; i++) begin
			sm[i] = right_s3 ? (MAGP_W'(mag_s3[i]) >> sh_s3) : (MAGP_W'(mag_s3[i]) << sh_s3);
		end
		su = (PR_W+2)'(pu_s5[0]) + (PR_W+2)'(pu_s5[1]) + (PR_W+2)'(pu_s5[2]);
		sw = (PR_W+2)'(pw_s5[0]) + (PR_W+2)'(pw_s5[1]) + (PR_W+2)'(pw_s5[2]);
		sc = $signed({1'b0, axis_scale});
		pos2 = lead_pos(mx_s8 | my_s8);
		smx = right_s9 ? (mx_s9 >> sh_s9) : (mx_s9 << sh_s9);
		smy = right_s9 ? (my_s9 >> sh_s9) : (my_s9 << sh_s9);
		hx = nx_s9 ? -$signed(X_W'(smx)) : $signed(X_W'(smx));
		hy = ny_s9 ? -$signed(X_W'(smy)) : $signed(X_W'(smy));
		hd.vld   = vld_q[9];
		hd.fix   = 1'b1;
		hd.degen = 1'b0;
		hd.x     = hx;
		hd.y     = hy;
		hd.z     = '0;
		if (zero_s9) begin
			hd.z = '0;
		end else if (none_s9) begin
			hd.degen = 1'b1;
		end else if (my_s9 == '0) begin
			hd.z = nx_s9 ? TURN_HALF : '0;
		end else if (mx_s9 == '0) begin
			hd.z = ny_s9 ? TURN_3QUART : TURN_QUARTER;
		end else if (nx_s9) begin
			hd.fix = 1'b0;
			hd.x   = -hx;
			hd.y   = -hy;
			hd.z   = TURN_HALF;
		end else begin
			hd.fix = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[8:1], take};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1[0] <= vec_x;
			v_s1[1] <= vec_y;
			v_s1[2] <= vec_z;

			for (int i = 0; i < 3; i++) begin
				neg_s2[i] <= v_s1[i][COORD_BITS-1];
				mag_s2[i] <= v_s1[i][COORD_BITS-1] ? unsigned'(-v_s1[i]) : unsigned'(v_s1[i]);
			end
			or_s2 <= (v_s1[0][COORD_BITS-1] ? unsigned'(-v_s1[0]) : unsigned'(v_s1[0]))
				| (v_s1[1][COORD_BITS-1] ? unsigned'(-v_s1[1]) : unsigned'(v_s1[1]))
				| (v_s1[2][COORD_BITS-1] ? unsigned'(-v_s1[2]) : unsigned'(v_s1[2]));

			mag_s3   <= mag_s2;
			neg_s3   <= neg_s2;
			zero_s3  <= (or_s2 == '0);
			right_s3 <= (pos1 > POS_W'(NV_TOP));
			sh_s3    <= (pos1 > POS_W'(NV_TOP)) ? (pos1 - POS_W'(NV_TOP)) : (POS_W'(NV_TOP) - pos1);

			for (int i = 0; i < 3; i++) begin
				nv_s4[i] <= neg_s3[i] ? -$signed(NV_W'(sm[i])) : $signed(NV_W'(sm[i]));
			end
			zero_s4 <= zero_s3;

			for (int i = 0; i < 3; i++) begin
				pu_s5[i] <= PR_W'(a1[i]) * PR_W'(nv_s4[i]);
				pw_s5[i] <= PR_W'(a2[i]) * PR_W'(nv_s4[i]);
			end
			zero_s5 <= zero_s4;

			u_s6    <= U_W'(su >>> 30);
			w_s6    <= U_W'(sw >>> 30);
			zero_s6 <= zero_s5;

			px_s7   <= P_W'(u_s6) * P_W'(sc);
			py_s7   <= P_W'(w_s6) <<< Y_FRAC;
			zero_s7 <= zero_s6;

			nx_s8   <= px_s7[P_W-1];
			ny_s8   <= py_s7[P_W-1];
			mx_s8   <= px_s7[P_W-1] ? unsigned'(-px_s7) : unsigned'(px_s7);
			my_s8   <= py_s7[P_W-1] ? unsigned'(-py_s7) : unsigned'(py_s7);
			zero_s8 <= zero_s7;

			mx_s9    <= mx_s8;
			my_s9    <= my_s8;
			nx_s9    <= nx_s8;
			ny_s9    <= ny_s8;
			zero_s9  <= zero_s8;
			none_s9  <= ((mx_s8 | my_s8) == '0);
			right_s9 <= (pos2 > POS_W'(P_TOP));
			sh_s9    <= (pos2 > POS_W'(P_TOP)) ? (pos2 - POS_W'(P_TOP)) : (POS_W'(P_TOP) - pos2);

			head <= hd;
		end
	end

endmodule
`default_nettype wire

// ===== sv/evpa_cell.sv =====
// One vectoring rotation cell of the angle chain.
`default_nettype none
module evpa_cell
	import evpa_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic [STEP_W-1:0]   step,
	input  wire cell_t               d,
	output cell_t                    q
);

	logic  vld_q;
	cell_t data_q;
	cell_t nxt;

	always_comb begin
		nxt = d;
		if (!d.fix) begin
			if (d.y >= 0) begin
				nxt.x = d.x + (d.y >>> step);
				nxt.y = d.y - (d.x >>> step);
				nxt.z = d.z + atan_turn(step);
			end else begin
				nxt.x = d.x - (d.y >>> step);
				nxt.y = d.y + (d.x >>> step);
				nxt.z = d.z - atan_turn(step);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	always_comb begin
		q     = data_q;
		q.vld = vld_q;
	end

endmodule
`default_nettype wire
